[rtl/core/iphs_pkg.sv]
// shared types and constants for the ip address hash set
// bucket row layout, operation codes, result fields and control states
// no dependencies
package iphs_pkg;

   // table geometry
   localparam int INDEX_BITS = 10;
   localparam int WAYS = 4;
   localparam int ADDR_W = 32;
   localparam int OP_W = 2;
   localparam int BUCKETS = 1 << INDEX_BITS;
   localparam int ROW_W = WAYS * (ADDR_W + 1);

   // stream payload widths
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_FIELDS_W = 3;
   localparam int RSP_TDATA_W = 8;

   // request operations; code three acts as check
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_CHECK  = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // one bucket row: valid bits and stored addresses
   typedef struct packed {
      logic [WAYS-1:0]             valid;
      logic [WAYS-1:0][ADDR_W-1:0] addr;
   } row_type;

   // result fields, was_present in the lowest bit
   typedef struct packed {
      logic bucket_full;
      logic inserted;
      logic was_present;
   } rsp_type;

   // outcome of one bucket lookup
   typedef struct packed {
      logic    wr;
      row_type row;
      rsp_type rsp;
   } update_type;

   // control states
   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_LOOKUP = 2'd2
   } state_type;

endpackage

[rtl/core/iphs_row_ram.sv]
// generic single-write, single-read synchronous memory
// read data registered
// no dependencies
module iphs_row_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[rtl/core/iphs_bucket_logic.sv]
// bucket row lookup and update for one request
// compares all ways, picks the first free slot, builds the new row
// depends on iphs_pkg
module iphs_bucket_logic (
   input  iphs_pkg::op_type     op,
   input  logic [31:0]          address,
   input  iphs_pkg::row_type    row,
   output iphs_pkg::update_type upd
);
   import iphs_pkg::*;

   logic [WAYS-1:0] hit_vec;
   logic [WAYS-1:0] hit_one;
   logic [WAYS-1:0] free_vec;
   logic [WAYS-1:0] free_one;

   // per-way match and lowest free slot
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = row.valid[w] && (row.addr[w] == address);
      end
      hit_one  = hit_vec & (~hit_vec + WAYS'(1));
      free_vec = ~row.valid;
      free_one = free_vec & (~free_vec + WAYS'(1));
   end

   // new row and result
   always_comb begin
      upd = '0;
      upd.row = row;
      upd.rsp.was_present = |hit_vec;
      case (op)
         OP_INSERT: begin
            if (!(|hit_vec)) begin
               if (|free_vec) begin
                  upd.wr = 1'b1;
                  upd.row.valid = row.valid | free_one;
                  for (int w = 0; w < WAYS; w++) begin
                     if (free_one[w]) begin
                        upd.row.addr[w] = address;
                     end
                  end
                  upd.rsp.inserted = 1'b1;
               end else begin
                  upd.rsp.bucket_full = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (|hit_vec) begin
               upd.wr = 1'b1;
               upd.row.valid = row.valid & ~hit_one;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/core/ip_address_hash_set_core.sv]
// top level of the ip address hash set: control, bucket memory, lookup
// depends on iphs_pkg, iphs_row_ram, iphs_bucket_logic
//
// channel | dir | transfer contents
// req     | in  | tdata[1:0] operation, tdata[33:2] address
// rsp     | out | tdata[0] was_present, [1] inserted, [2] bucket_full
//
// for each request the bucket row is read from memory in the accept cycle
// and, if changed, written back with the result once the result register is free
// the result register frees the request side: a new request is taken
// while an earlier result still waits on rsp_tready
// after reset a clearing pass zeroes every row's valid bits;
// req_tready stays low until it ends
module ip_address_hash_set_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] operation, [33:2] address, [39:34] zero
   input  logic [iphs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] was_present, [1] inserted, [2] bucket_full, [7:3] zero
   output logic [iphs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import iphs_pkg::*;

   state_type              state_ff, state_in;
   logic [INDEX_BITS-1:0]  clr_ff, clr_in;
   op_type                 op_ff, op_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   req_xfer;
   logic                   rsp_load;
   logic                   ram_wr_en;
   logic [INDEX_BITS-1:0]  ram_wr_addr;
   logic [ROW_W-1:0]       ram_wr_data;
   logic [ROW_W-1:0]       ram_rd_data;
   row_type                rd_row;
   update_type             upd;

   assign req_xfer = req_tvalid && req_tready;
   assign rd_row = row_type'(ram_rd_data);

   // bucket row memory
   iphs_row_ram #(
      .DATA_W (ROW_W),
      .ADDR_W (INDEX_BITS)
   ) u_row_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (req_xfer),
      .rd_addr    (req_tdata[OP_W +: INDEX_BITS]),
      .rd_data_ff (ram_rd_data)
   );

   // lookup and update of the fetched row
   iphs_bucket_logic u_bucket_logic (
      .op      (op_ff),
      .address (addr_ff),
      .row     (rd_row),
      .upd     (upd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == {INDEX_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready  = 1'b0;
      rsp_load    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff[INDEX_BITS-1:0];
      ram_wr_data = ROW_W'(upd.row);
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_LOOKUP: begin
            rsp_load  = !rsp_valid_ff || rsp_tready;
            ram_wr_en = rsp_load && upd.wr;
         end
         default: begin
         end
      endcase
   end

   // datapath register next values
   always_comb begin
      clr_in       = (state_ff == ST_CLEAR) ? clr_ff + INDEX_BITS'(1) : clr_ff;
      op_in        = req_xfer ? op_type'(req_tdata[OP_W-1:0]) : op_ff;
      addr_in      = req_xfer ? req_tdata[OP_W +: ADDR_W] : addr_ff;
      rsp_in       = rsp_load ? upd.rsp : rsp_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, rsp_ff};

   // an accepted request is looked up in the next cycle
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_LOOKUP)
      else $error("accepted request did not move to lookup");

   // no result leaves during the clearing pass
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_tvalid)
      else $error("result presented during clearing pass");

   // a new insert cannot have been present
   a_insert_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.inserted |-> !rsp_ff.was_present && !rsp_ff.bucket_full)
      else $error("inserted result with present or full flag");

   // write back of a lookup happens only when its result is loaded
   a_wb_with_result: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && state_ff == ST_LOOKUP |=> rsp_tvalid)
      else $error("row written back without a result");

endmodule

[tb/sv/tb_ip_address_hash_set_core.sv]
// self-checking testbench for ip_address_hash_set_core over its req and rsp streams
// holds its own copy of the bucket table and predicts every result
// depends on iphs_pkg and the ip_address_hash_set_core rtl
`timescale 1ns / 1ps

module tb_ip_address_hash_set_core;
   import iphs_pkg::*;

   // op code three has no name in the package; the block treats it as check
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_REQS = 850;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AT = 650;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [1:0] operation, [33:2] address, [39:34] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [0] was_present, [1] inserted, [2] bucket_full, [7:3] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // requests waiting to be offered and results waiting to arrive
   logic [REQ_TDATA_W-1:0] pending_reqs[$];
   rsp_type expected_rsps[$];

   // shadow copy of the bucket table
   logic [ADDR_W-1:0] shadow_addr[BUCKETS][WAYS];
   bit shadow_valid[BUCKETS][WAYS];

   int n_accepted = 0;
   int n_errors = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   ip_address_hash_set_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // look up one address in the shadow table, apply the operation, return its result
   function automatic rsp_type apply_set_op(input logic [OP_W-1:0] op,
                                            input logic [ADDR_W-1:0] addr);
      int bkt;
      int hit;
      int free_way;
      rsp_type res;
      bkt = int'(addr[INDEX_BITS-1:0]);
      hit = -1;
      free_way = -1;
      res = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (shadow_valid[bkt][w]) begin
            if (hit < 0 && shadow_addr[bkt][w] == addr) hit = w;
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      res.was_present = (hit >= 0);
      if (op == OP_INSERT) begin
         if (hit < 0) begin
            if (free_way >= 0) begin
               shadow_addr[bkt][free_way] = addr;
               shadow_valid[bkt][free_way] = 1'b1;
               res.inserted = 1'b1;
            end else begin
               res.bucket_full = 1'b1;
            end
         end
      end else if (op == OP_REMOVE) begin
         if (hit >= 0) shadow_valid[bkt][hit] = 1'b0;
      end
      return res;
   endfunction

   task automatic queue_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
      pending_reqs.push_back({{(REQ_TDATA_W - ADDR_W - OP_W){1'b0}}, addr, op});
   endtask

   // idle percentages per phase: sender 19 / receiver 66, then swapped, then none
   function automatic int sender_idle_pct(input int accepted);
      if (accepted < 300) return 19;
      if (accepted < 600) return 66;
      return 0;
   endfunction

   function automatic int receiver_idle_pct(input int accepted);
      if (accepted < 300) return 66;
      if (accepted < 600) return 19;
      return 0;
   endfunction

   // request driver: predicts each accepted transfer and offers the next one
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(apply_set_op(req_tdata[OP_W-1:0],
                                                 req_tdata[OP_W +: ADDR_W]));
            n_accepted <= n_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 &&
                $urandom_range(0, 99) >= sender_idle_pct(n_accepted)) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_reqs.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compares each transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
            if (expected_rsps.size() == 0) begin
               $error("result transfer with no prediction waiting: %b", rsp_tdata);
               n_errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.was_present !== want.was_present) begin
                  $error("was_present: expected %b, got %b", want.was_present,
                         got.was_present);
                  n_errors++;
               end
               if (got.inserted !== want.inserted) begin
                  $error("inserted: expected %b, got %b", want.inserted, got.inserted);
                  n_errors++;
               end
               if (got.bucket_full !== want.bucket_full) begin
                  $error("bucket_full: expected %b, got %b", want.bucket_full,
                         got.bucket_full);
                  n_errors++;
               end
            end
         end
         // one long hold-off late in the run so the block backs up into req
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && n_accepted >= HOLD_OFF_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct(n_accepted));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] hot_buckets[6];
      logic [ADDR_W-1:0] addr;
      logic [OP_W-1:0] op;
      int pick;
      for (int b = 0; b < BUCKETS; b++)
         for (int w = 0; w < WAYS; w++) begin
            shadow_valid[b][w] = 1'b0;
            shadow_addr[b][w] = '0;
         end

      // directed: field extremes, every operation, each corner of the set
      queue_req(OP_INSERT, 32'h0000_0000);
      queue_req(OP_INSERT, 32'hFFFF_FFFF);
      queue_req(OP_CHECK, 32'h0000_0000);
      queue_req(OP_CHECK, 32'hFFFF_FFFF);
      queue_req(OP_INSERT, 32'h0000_0000);              // already present
      queue_req(OP_CHECK, 32'h0000_0400);               // same bucket, absent
      for (int t = 1; t <= WAYS; t++) queue_req(OP_INSERT, (t << INDEX_BITS) | 5);
      queue_req(OP_INSERT, (5 << INDEX_BITS) | 5);      // bucket full
      queue_req(OP_REMOVE, (2 << INDEX_BITS) | 5);
      queue_req(OP_INSERT, (5 << INDEX_BITS) | 5);      // reuses the freed slot
      queue_req(OP_INSERT, (2 << INDEX_BITS) | 5);      // full again
      queue_req(OP_REMOVE, (9 << INDEX_BITS) | 5);      // remove of an absent address
      queue_req(OP_UNUSED, (5 << INDEX_BITS) | 5);      // unused code acts as check
      queue_req(OP_UNUSED, (9 << INDEX_BITS) | 5);
      queue_req(OP_REMOVE, 32'h0000_0000);
      queue_req(OP_CHECK, 32'h0000_0000);
      queue_req(OP_REMOVE, 32'hFFFF_FFFF);
      queue_req(OP_INSERT, 32'hAAAA_AAAA);
      queue_req(OP_CHECK, 32'h5555_5555);
      queue_req(OP_REMOVE, 32'hAAAA_AAAA);

      // random: mostly a few crowded buckets so hits, fills and frees recur
      hot_buckets[0] = 0;
      hot_buckets[1] = 1;
      hot_buckets[2] = 511;
      hot_buckets[3] = BUCKETS - 1;
      hot_buckets[4] = $urandom_range(0, BUCKETS - 1);
      hot_buckets[5] = $urandom_range(0, BUCKETS - 1);
      for (int i = 0; i < RANDOM_REQS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) op = OP_INSERT;
         else if (pick < 65) op = OP_CHECK;
         else if (pick < 90) op = OP_REMOVE;
         else op = OP_UNUSED;
         if ($urandom_range(0, 99) < 80) begin
            addr = ($urandom_range(0, 5) << INDEX_BITS) | hot_buckets[$urandom_range(0, 5)];
            if ($urandom_range(0, 9) == 0) addr[ADDR_W-1:INDEX_BITS] = '1;
         end else begin
            addr = $urandom();
         end
         queue_req(op, addr);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // wait for every request to be taken and every result to arrive
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_errors == 0 && expected_rsps.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
